// ----- rtl/ncq_pkg.sv -----
// package: shared types, register codes, rule tables and default sizes for the quadrature block
`default_nettype none

package ncq_pkg;

    localparam int SAMPLE_WIDTH_DEF  = 32;
    localparam int FRACTION_BITS_DEF = 24;
    localparam int COUNT_WIDTH_DEF   = 16;

    localparam int ACC_WIDTH   = 64;
    localparam int WEIGHT_W    = 6;
    localparam int FAC_NUM_W   = 2;
    localparam int FAC_DEN_W   = 6;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int COUNT_REG_W = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_RULE  = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LOWER = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_UPPER = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COUNT = 2'd3;

    localparam logic [1:0] RULE_TRAPEZOID = 2'd0;
    localparam logic [1:0] RULE_SIMPSON3  = 2'd1;
    localparam logic [1:0] RULE_SIMPSON8  = 2'd2;
    localparam logic [1:0] RULE_BOOLE     = 2'd3;

    localparam logic [CFG_DATA_W-1:0] LOWER_RESET = 32'd0;
    localparam logic [CFG_DATA_W-1:0] UPPER_RESET = 32'd16777216;
    localparam logic [COUNT_REG_W-1:0] COUNT_RESET = 16'd12;

    typedef struct packed {
        logic accept;
        logic load;
        logic prep;
        logic mul_step;
        logic div_init;
        logic div_step;
        logic out_load;
    } ncq_cmd_t;

    typedef struct packed {
        logic last;
    } ncq_sts_t;

    function automatic logic [WEIGHT_W-1:0] edge_weight(input logic [1:0] rule);
        logic [WEIGHT_W-1:0] w;
        unique case (rule)
            RULE_BOOLE: w = 6'd7;
            default:    w = 6'd1;
        endcase
        return w;
    endfunction

    function automatic logic [WEIGHT_W-1:0] mid_weight(input logic [1:0] rule,
                                                       input logic [1:0] phase);
        logic [WEIGHT_W-1:0] w;
        unique case (rule)
            RULE_TRAPEZOID: w = 6'd2;
            RULE_SIMPSON3:  w = phase[0] ? 6'd2 : 6'd4;
            RULE_SIMPSON8:  w = (phase == 2'd2) ? 6'd2 : 6'd3;
            RULE_BOOLE:
            begin
                unique case (phase)
                    2'd0:    w = 6'd32;
                    2'd1:    w = 6'd12;
                    2'd2:    w = 6'd32;
                    default: w = 6'd14;
                endcase
            end
            default:        w = 6'd2;
        endcase
        return w;
    endfunction

    function automatic logic [2:0] cycle_len(input logic [1:0] rule);
        return {1'b0, rule} + 3'd1;
    endfunction

    function automatic logic [FAC_NUM_W-1:0] fac_num(input logic [1:0] rule);
        logic [FAC_NUM_W-1:0] v;
        unique case (rule)
            RULE_SIMPSON8: v = 2'd3;
            RULE_BOOLE:    v = 2'd2;
            default:       v = 2'd1;
        endcase
        return v;
    endfunction

    function automatic logic [FAC_DEN_W-1:0] fac_den(input logic [1:0] rule);
        logic [FAC_DEN_W-1:0] v;
        unique case (rule)
            RULE_TRAPEZOID: v = 6'd2;
            RULE_SIMPSON3:  v = 6'd3;
            RULE_SIMPSON8:  v = 6'd8;
            default:        v = 6'd45;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/ncq_if.sv -----
// interfaces: sample, result and configuration write channels
`default_nettype none

interface ncq_sample_if #(parameter int SAMPLE_WIDTH = ncq_pkg::SAMPLE_WIDTH_DEF);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface ncq_result_if #(parameter int SAMPLE_WIDTH = ncq_pkg::SAMPLE_WIDTH_DEF);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] integral;
    logic                           saturated;

    modport source (output valid, output integral, output saturated, input ready);
    modport sink   (input valid, input integral, input saturated, output ready);
endinterface

interface ncq_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [ncq_pkg::CFG_INDEX_W-1:0]    index;
    logic [ncq_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/ncq_ctrl.sv -----
// controller: sequences accumulation, scaling multiply, divide and result transfer
`default_nettype none

module ncq_ctrl #(
    parameter int MUL_STEPS = 64,
    parameter int DIV_STEPS = 100
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output      logic              in_ready,
    output      logic              out_valid,
    input  wire logic              out_ready,
    input  wire ncq_pkg::ncq_sts_t sts,
    output      ncq_pkg::ncq_cmd_t cmd
);
    import ncq_pkg::*;

    localparam int MAX_STEPS = (MUL_STEPS > DIV_STEPS) ? MUL_STEPS : DIV_STEPS;
    localparam int ITER_W    = $clog2(MAX_STEPS);

    localparam logic [2:0] S_ACCUM = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_PREP  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_DINIT = 3'd4;
    localparam logic [2:0] S_DIV   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]        state_reg, state_next;
    logic [ITER_W-1:0] cnt_reg, cnt_next;
    logic              out_valid_reg, out_valid_next;

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_ACCUM:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (sts.last)
                    begin
                        state_next = S_LOAD;
                    end
                end
            end
            S_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                cnt_next   = ITER_W'(MUL_STEPS - 1);
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_DINIT;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_DINIT:
            begin
                cmd.div_init = 1'b1;
                cnt_next     = ITER_W'(DIV_STEPS - 1);
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_ACCUM;
                end
            end
            default:
            begin
                state_next = S_ACCUM;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_ACCUM;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == S_ACCUM);
    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- rtl/ncq_datapath.sv -----
// datapath: config registers, weighted accumulator, shift-add multiplier, restoring divider
`default_nettype none

module ncq_datapath #(
    parameter int SAMPLE_WIDTH  = ncq_pkg::SAMPLE_WIDTH_DEF,
    parameter int FRACTION_BITS = ncq_pkg::FRACTION_BITS_DEF,
    parameter int COUNT_WIDTH   = ncq_pkg::COUNT_WIDTH_DEF,
    parameter int NUM_W         = 100
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_write,
    input  wire logic [ncq_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [ncq_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic signed [SAMPLE_WIDTH-1:0]    sample,
    input  wire ncq_pkg::ncq_cmd_t                 cmd,
    output      ncq_pkg::ncq_sts_t                 sts,
    output      logic signed [SAMPLE_WIDTH-1:0]    integral,
    output      logic                              saturated
);
    import ncq_pkg::*;

    localparam int SW     = SAMPLE_WIDTH;
    localparam int CW     = COUNT_WIDTH;
    localparam int ACC_W  = ACC_WIDTH;
    localparam int WP_W   = SW + WEIGHT_W + 1;
    localparam int DIFF_W = SW + 1;
    localparam int DNUM_W = SW + 2;
    localparam int PROD_W = ACC_W + DNUM_W;
    localparam int BASE_W = CW + FAC_DEN_W;
    localparam int DEN_W  = BASE_W + FRACTION_BITS;
    localparam int REM_W  = DEN_W + 2;

    logic [1:0]          rule_reg, rule_next;
    logic [SW-1:0]       lower_reg, lower_next;
    logic [SW-1:0]       upper_reg, upper_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       idx_reg, idx_next;
    logic [1:0]          phase_reg, phase_next;
    logic [ACC_W-1:0]    sum_reg, sum_next;

    logic [ACC_W-1:0]    smag_reg, smag_next;
    logic                sneg_reg, sneg_next;
    logic [DIFF_W-1:0]   diff_reg, diff_next;
    logic                dneg_reg, dneg_next;
    logic [PROD_W-1:0]   mcand_reg, mcand_next;
    logic [ACC_W-1:0]    mplier_reg, mplier_next;
    logic [PROD_W-1:0]   prod_reg, prod_next;
    logic [DEN_W-1:0]    den_reg, den_next;
    logic [NUM_W-1:0]    num_reg, num_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [NUM_W-1:0]    quot_reg, quot_next;
    logic [SW-1:0]       integral_reg, integral_next;
    logic                sat_reg, sat_next;

    logic [CW-1:0]          n_eff;
    logic                   is_first;
    logic                   is_last;
    logic [WEIGHT_W-1:0]    weight;
    logic signed [WP_W-1:0] wprod;
    logic [2:0]             phase_inc;
    logic [DIFF_W-1:0]      dmag;
    logic [DNUM_W-1:0]      dnum;
    logic [BASE_W-1:0]      base;
    logic [REM_W-1:0]       rem_sh;
    logic [REM_W-1:0]       den2;
    logic                   rem_ge;
    logic                   neg;
    logic [SW-1:0]          limit;
    logic                   over;
    logic [SW-1:0]          qv;

    assign n_eff     = (count_reg == '0) ? CW'(1) : count_reg;
    assign is_first  = (idx_reg == '0);
    assign is_last   = (idx_reg >= n_eff);
    assign weight    = (is_first || is_last) ? edge_weight(rule_reg)
                                             : mid_weight(rule_reg, phase_reg);
    assign wprod     = $signed({1'b0, weight}) * sample;
    assign phase_inc = {1'b0, phase_reg} + 3'd1;
    assign sts.last  = is_last;

    assign dmag   = diff_reg[DIFF_W-1] ? (~diff_reg + 1'b1) : diff_reg;
    assign dnum   = DNUM_W'(dmag) * DNUM_W'(fac_num(rule_reg));
    assign base   = BASE_W'(n_eff) * BASE_W'(fac_den(rule_reg));

    assign rem_sh = {rem_reg[REM_W-2:0], num_reg[NUM_W-1]};
    assign den2   = {1'b0, den_reg, 1'b0};
    assign rem_ge = (rem_sh >= den2);

    assign neg    = sneg_reg ^ dneg_reg;
    assign limit  = neg ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
    assign over   = (quot_reg > NUM_W'(limit));
    assign qv     = over ? limit : quot_reg[SW-1:0];

    always_comb
    begin
        rule_next  = rule_reg;
        lower_next = lower_reg;
        upper_next = upper_reg;
        count_next = count_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_RULE:  rule_next  = cfg_data[1:0];
                REG_LOWER: lower_next = SW'(cfg_data);
                REG_UPPER: upper_next = SW'(cfg_data);
                REG_COUNT: count_next = CW'(cfg_data[COUNT_REG_W-1:0]);
                default:   rule_next  = rule_reg;
            endcase
        end
    end

    always_comb
    begin
        idx_next   = idx_reg;
        phase_next = phase_reg;
        sum_next   = sum_reg;
        if (cmd.accept)
        begin
            sum_next = sum_reg + {{(ACC_W-WP_W){wprod[WP_W-1]}}, wprod};
            if (is_last)
            begin
                idx_next   = '0;
                phase_next = 2'd0;
            end
            else
            begin
                idx_next = idx_reg + 1'b1;
                if (!is_first)
                begin
                    phase_next = (phase_inc >= cycle_len(rule_reg)) ? 2'd0 : phase_inc[1:0];
                end
            end
        end
        else if (cmd.load)
        begin
            sum_next = '0;
        end
    end

    always_comb
    begin
        smag_next     = smag_reg;
        sneg_next     = sneg_reg;
        diff_next     = diff_reg;
        dneg_next     = dneg_reg;
        mcand_next    = mcand_reg;
        mplier_next   = mplier_reg;
        prod_next     = prod_reg;
        den_next      = den_reg;
        num_next      = num_reg;
        rem_next      = rem_reg;
        quot_next     = quot_reg;
        integral_next = integral_reg;
        sat_next      = sat_reg;
        if (cmd.load)
        begin
            sneg_next = sum_reg[ACC_W-1];
            smag_next = sum_reg[ACC_W-1] ? (~sum_reg + 1'b1) : sum_reg;
            diff_next = {upper_reg[SW-1], upper_reg} - {lower_reg[SW-1], lower_reg};
        end
        if (cmd.prep)
        begin
            dneg_next   = diff_reg[DIFF_W-1];
            mcand_next  = PROD_W'(dnum);
            mplier_next = smag_reg;
            prod_next   = '0;
            den_next    = DEN_W'(base) << FRACTION_BITS;
        end
        if (cmd.mul_step)
        begin
            if (mplier_reg[0])
            begin
                prod_next = prod_reg + mcand_reg;
            end
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
        end
        if (cmd.div_init)
        begin
            // round to nearest: (2*prod + den) / (2*den)
            num_next  = NUM_W'({prod_reg, 1'b0}) + NUM_W'(den_reg);
            rem_next  = '0;
            quot_next = '0;
        end
        if (cmd.div_step)
        begin
            rem_next  = rem_ge ? (rem_sh - den2) : rem_sh;
            quot_next = {quot_reg[NUM_W-2:0], rem_ge};
            num_next  = num_reg << 1;
        end
        if (cmd.out_load)
        begin
            integral_next = neg ? (~qv + 1'b1) : qv;
            sat_next      = over;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rule_reg  <= RULE_TRAPEZOID;
            lower_reg <= SW'(LOWER_RESET);
            upper_reg <= SW'(UPPER_RESET);
            count_reg <= CW'(COUNT_RESET);
            idx_reg   <= '0;
            phase_reg <= 2'd0;
            sum_reg   <= '0;
        end
        else
        begin
            rule_reg  <= rule_next;
            lower_reg <= lower_next;
            upper_reg <= upper_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            phase_reg <= phase_next;
            sum_reg   <= sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        smag_reg     <= smag_next;
        sneg_reg     <= sneg_next;
        diff_reg     <= diff_next;
        dneg_reg     <= dneg_next;
        mcand_reg    <= mcand_next;
        mplier_reg   <= mplier_next;
        prod_reg     <= prod_next;
        den_reg      <= den_next;
        num_reg      <= num_next;
        rem_reg      <= rem_next;
        quot_reg     <= quot_next;
        integral_reg <= integral_next;
        sat_reg      <= sat_next;
    end

    assign integral  = integral_reg;
    assign saturated = sat_reg;

endmodule

`default_nettype wire

// ----- rtl/newton_cotes_quadrature.sv -----
// top level: composite newton-cotes quadrature over a stream of equally spaced samples
// samples are taken one per cycle; n+1 transfers make one integral
// after the last sample the sum is scaled by the shift-add multiplier and the restoring divider
// no sample is taken during that scaling; one result may wait in the output register meanwhile
// asynchronous active-low reset clears the accumulator and loads the config register defaults
`default_nettype none

module newton_cotes_quadrature #(
    parameter int SAMPLE_WIDTH  = ncq_pkg::SAMPLE_WIDTH_DEF,
    parameter int FRACTION_BITS = ncq_pkg::FRACTION_BITS_DEF,
    parameter int COUNT_WIDTH   = ncq_pkg::COUNT_WIDTH_DEF
) (
    input wire logic    clk,
    input wire logic    rst_n,
    ncq_cfg_if.sink     cfg,
    ncq_sample_if.sink  samples,
    ncq_result_if.source results
);
    import ncq_pkg::*;

    localparam int PROD_W = ACC_WIDTH + SAMPLE_WIDTH + 2;
    localparam int DEN_W  = COUNT_WIDTH + FAC_DEN_W + FRACTION_BITS;
    localparam int NUM_W  = ((PROD_W > DEN_W) ? PROD_W : DEN_W) + 2;

    ncq_cmd_t cmd;
    ncq_sts_t sts;

    assign cfg.ready = 1'b1;

    ncq_ctrl #(
        .MUL_STEPS (ACC_WIDTH),
        .DIV_STEPS (NUM_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (samples.valid),
        .in_ready  (samples.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    ncq_datapath #(
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .FRACTION_BITS (FRACTION_BITS),
        .COUNT_WIDTH   (COUNT_WIDTH),
        .NUM_W         (NUM_W)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg.valid),
        .cfg_index (cfg.index),
        .cfg_data  (cfg.data),
        .sample    (samples.sample),
        .cmd       (cmd),
        .sts       (sts),
        .integral  (results.integral),
        .saturated (results.saturated)
    );

endmodule

`default_nettype wire

// ----- rtl/ncq_checker.sv -----
// checker: port-level assertions for the quadrature block, bound to the top level
`default_nettype none

module ncq_port_checker #(
    parameter int SAMPLE_WIDTH = ncq_pkg::SAMPLE_WIDTH_DEF
) (
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    in_valid,
    input wire logic                    in_ready,
    input wire logic                    out_valid,
    input wire logic                    out_ready,
    input wire logic [SAMPLE_WIDTH-1:0] integral,
    input wire logic                    saturated
);
    localparam logic [SAMPLE_WIDTH-1:0] POS_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
    localparam logic [SAMPLE_WIDTH-1:0] NEG_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped before transfer");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(integral) && $stable(saturated))
        else $error("stalled result changed");

    a_sat_extreme: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |-> integral == POS_MAX || integral == NEG_MIN)
        else $error("saturated result not at range limit");

    a_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_valid && in_ready))
        else $error("result appeared right after a sample transfer");

endmodule

bind newton_cotes_quadrature ncq_port_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_ncq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (samples.valid),
    .in_ready  (samples.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .integral  (results.integral),
    .saturated (results.saturated)
);

`default_nettype wire
